FILE: design/orl_pkg.sv
// Shared types and constants for the ordered record list.
package orl_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int OP_W         = 3;
  localparam int POS_W        = 5;
  localparam int KEY_W        = 64;
  localparam int GENDER_W     = 8;
  localparam int SCORE_W      = 16;
  localparam int STATUS_W     = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT   = 3'd0,
    OP_DELETE   = 3'd1,
    OP_GET      = 3'd2,
    OP_MODIFY   = 3'd3,
    OP_LOC_ID   = 3'd4,
    OP_LOC_NAME = 3'd5,
    OP_INVERT   = 3'd6,
    OP_CLEAR    = 3'd7
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_BADPOS    = 2'd3
  } status_t;

  typedef struct packed {
    logic [KEY_W-1:0]           id;
    logic [KEY_W-1:0]           name;
    logic [GENDER_W-1:0]        gender;
    logic signed [SCORE_W-1:0]  score;
  } rec_t;

  typedef enum logic [2:0] {
    CMD_HOLD   = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_DELETE = 3'd2,
    CMD_MODIFY = 3'd3,
    CMD_MIRROR = 3'd4,
    CMD_SHIFT  = 3'd5
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t        cmd;
    logic             by_name;
    logic [KEY_W-1:0] key;
  } cell_ctrl_t;

endpackage

FILE: design/orl_cell.sv
// One list cell: holds a record, shifts with its neighbors and matches a key.
module orl_cell #(
  parameter int CAPACITY = orl_pkg::CAPACITY_DEF,
  parameter int INDEX    = 0
) (
  input  logic                        clk,
  input  orl_pkg::cell_ctrl_t         ctrl,
  input  logic [$clog2(CAPACITY)-1:0] tgt,
  input  logic [$clog2(CAPACITY+1)-1:0] count,
  input  orl_pkg::rec_t               item,
  input  orl_pkg::rec_t               left,
  input  orl_pkg::rec_t               right,
  input  orl_pkg::rec_t               mirror,
  output orl_pkg::rec_t               rec,
  output logic                        match
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [IW-1:0] MY_IDX = IW'(INDEX);
  localparam logic [CW-1:0] MY_CNT = CW'(INDEX);

  orl_pkg::rec_t rec_next;

  always_comb begin
    rec_next = rec;
    unique case (ctrl.cmd)
      orl_pkg::CMD_INSERT: begin
        if (MY_IDX > tgt) begin
          rec_next = left;
        end else if (MY_IDX == tgt) begin
          rec_next = item;
        end
      end
      orl_pkg::CMD_DELETE: begin
        if (MY_IDX >= tgt) begin
          rec_next = right;
        end
      end
      orl_pkg::CMD_MODIFY: begin
        if (MY_IDX == tgt) begin
          rec_next = item;
        end
      end
      orl_pkg::CMD_MIRROR: rec_next = mirror;
      orl_pkg::CMD_SHIFT:  rec_next = right;
      default:             rec_next = rec;
    endcase
  end

  always_ff @(posedge clk) begin
    rec <= rec_next;
  end

  assign match = (MY_CNT < count) && ((ctrl.by_name ? rec.name : rec.id) == ctrl.key);

endmodule

FILE: design/ordered_record_list.sv
// Top level of the ordered record list: sequencer, count and result register.
//
// A bounded ordered list of up to CAPACITY records held in a chain of cells, one record
// per cell. Insert, delete, get, modify, clear and every error case finish in the cycle the
// item is accepted: the result shows up in the next cycle and the next item can go in then.
// Locate has every cell compare its key and registers the matches, then encodes the first match.
// Invert of fewer than two records also finishes in the cycle it is accepted. Otherwise it
// mirrors the whole chain in one step and then shifts it down one cell per cycle until the
// held records start at position 1, and only then gives its result.
// The result register lets a new item in while the previous result waits to be taken,
// provided that result is taken in the same cycle.
module ordered_record_list #(
  parameter int CAPACITY = orl_pkg::CAPACITY_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_ready,
  input  logic [orl_pkg::OP_W-1:0]           operation,
  input  logic [orl_pkg::POS_W-1:0]          position,
  input  logic [orl_pkg::KEY_W-1:0]          student_id,
  input  logic [orl_pkg::KEY_W-1:0]          student_name,
  input  logic [orl_pkg::GENDER_W-1:0]       gender_code,
  input  logic signed [orl_pkg::SCORE_W-1:0] score_value,
  output logic                               rsp_valid,
  input  logic                               rsp_ready,
  output logic [orl_pkg::STATUS_W-1:0]       status,
  output logic [orl_pkg::POS_W-1:0]          found_position,
  output logic [orl_pkg::KEY_W-1:0]          out_id,
  output logic [orl_pkg::KEY_W-1:0]          out_name,
  output logic [orl_pkg::GENDER_W-1:0]       out_gender,
  output logic signed [orl_pkg::SCORE_W-1:0] out_score,
  output logic [orl_pkg::POS_W-1:0]          entry_count
);

  localparam int IW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = ((CW > orl_pkg::POS_W) ? CW : orl_pkg::POS_W) + 1;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_MIRROR = 3'b010,
    S_LOCATE = 3'b100
  } state_t;

  state_t              state, state_next;
  logic [CW-1:0]       count, count_next;
  logic [CW-1:0]       shift_cnt, shift_cnt_next;
  logic [CAPACITY-1:0] match_q;
  logic [CAPACITY-1:0] cell_match;
  orl_pkg::rec_t       cell_rec [CAPACITY];

  orl_pkg::cell_ctrl_t ctrl;
  orl_pkg::rec_t       item;
  orl_pkg::op_t        op;
  logic                accept;
  logic                emit;
  logic                rd_en;
  logic                match_load;
  orl_pkg::status_t    st;
  logic [orl_pkg::POS_W-1:0] found;
  logic [CMPW-1:0]     pos_e, cnt_e;
  logic [IW-1:0]       tgt;
  logic                pos_ok, ins_ok, full;

  assign op   = orl_pkg::op_t'(operation);
  assign item = '{id: student_id, name: student_name, gender: gender_code, score: score_value};

  assign req_ready = (state == S_IDLE) && (!rsp_valid || rsp_ready);
  assign accept    = req_valid && req_ready;

  assign pos_e  = CMPW'(position);
  assign cnt_e  = CMPW'(count);
  assign tgt    = IW'(pos_e - CMPW'(1));
  assign pos_ok = (position != '0) && (pos_e <= cnt_e);
  assign ins_ok = (position != '0) && (pos_e <= cnt_e + CMPW'(1));
  assign full   = (count == CW'(CAPACITY));

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    orl_pkg::rec_t left_rec, right_rec;
    if (i == 0) begin : g_first
      assign left_rec = item;
    end else begin : g_mid_l
      assign left_rec = cell_rec[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_rec = cell_rec[i];
    end else begin : g_mid_r
      assign right_rec = cell_rec[i+1];
    end
    orl_cell #(
      .CAPACITY (CAPACITY),
      .INDEX    (i)
    ) u_cell (
      .clk    (clk),
      .ctrl   (ctrl),
      .tgt    (tgt),
      .count  (count),
      .item   (item),
      .left   (left_rec),
      .right  (right_rec),
      .mirror (cell_rec[CAPACITY-1-i]),
      .rec    (cell_rec[i]),
      .match  (cell_match[i])
    );
  end

  always_comb begin
    ctrl.cmd       = orl_pkg::CMD_HOLD;
    ctrl.by_name   = (op == orl_pkg::OP_LOC_NAME);
    ctrl.key       = (op == orl_pkg::OP_LOC_NAME) ? student_name : student_id;
    state_next     = state;
    count_next     = count;
    shift_cnt_next = shift_cnt;
    emit           = 1'b0;
    rd_en          = 1'b0;
    match_load     = 1'b0;
    st             = orl_pkg::ST_OK;
    found          = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (op)
            orl_pkg::OP_INSERT: begin
              emit = 1'b1;
              if (full) begin
                st = orl_pkg::ST_OVERFLOW;
              end else if (!ins_ok) begin
                st = orl_pkg::ST_BADPOS;
              end else begin
                ctrl.cmd   = orl_pkg::CMD_INSERT;
                count_next = count + CW'(1);
              end
            end
            orl_pkg::OP_DELETE: begin
              emit = 1'b1;
              if (count == '0) begin
                st = orl_pkg::ST_UNDERFLOW;
              end else if (!pos_ok) begin
                st = orl_pkg::ST_BADPOS;
              end else begin
                ctrl.cmd   = orl_pkg::CMD_DELETE;
                rd_en      = 1'b1;
                count_next = count - CW'(1);
              end
            end
            orl_pkg::OP_GET: begin
              emit = 1'b1;
              if (!pos_ok) begin
                st = orl_pkg::ST_BADPOS;
              end else begin
                rd_en = 1'b1;
              end
            end
            orl_pkg::OP_MODIFY: begin
              emit = 1'b1;
              if (!pos_ok) begin
                st = orl_pkg::ST_BADPOS;
              end else begin
                ctrl.cmd = orl_pkg::CMD_MODIFY;
              end
            end
            orl_pkg::OP_LOC_ID, orl_pkg::OP_LOC_NAME: begin
              match_load = 1'b1;
              state_next = S_LOCATE;
            end
            orl_pkg::OP_INVERT: begin
              if (count < CW'(2)) begin
                emit = 1'b1;
              end else begin
                // mirror the full chain, then slide the records down to position 1
                ctrl.cmd       = orl_pkg::CMD_MIRROR;
                shift_cnt_next = CW'(CAPACITY) - count;
                state_next     = S_MIRROR;
              end
            end
            default: begin
              emit       = 1'b1;
              count_next = '0;
            end
          endcase
        end
      end
      S_MIRROR: begin
        if (shift_cnt != '0) begin
          ctrl.cmd       = orl_pkg::CMD_SHIFT;
          shift_cnt_next = shift_cnt - CW'(1);
        end else begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_LOCATE: begin
        for (int i = CAPACITY - 1; i >= 0; i--) begin
          if (match_q[i]) begin
            found = orl_pkg::POS_W'(i + 1);
          end
        end
        emit       = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      shift_cnt <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      shift_cnt <= shift_cnt_next;
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (match_load) begin
      match_q <= cell_match;
    end
    if (emit) begin
      status         <= st;
      found_position <= found;
      entry_count    <= orl_pkg::POS_W'(count_next);
      if (rd_en) begin
        out_id     <= cell_rec[tgt].id;
        out_name   <= cell_rec[tgt].name;
        out_gender <= cell_rec[tgt].gender;
        out_score  <= cell_rec[tgt].score;
      end else begin
        out_id     <= '0;
        out_name   <= '0;
        out_gender <= '0;
        out_score  <= '0;
      end
    end
  end

endmodule

FILE: test/orl_checker.sv
// Checker for the ordered record list: tracks the list, predicts every result and compares.
module orl_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  input  logic                               req_ready,
  input  logic [orl_pkg::OP_W-1:0]           operation,
  input  logic [orl_pkg::POS_W-1:0]          position,
  input  logic [orl_pkg::KEY_W-1:0]          student_id,
  input  logic [orl_pkg::KEY_W-1:0]          student_name,
  input  logic [orl_pkg::GENDER_W-1:0]       gender_code,
  input  logic signed [orl_pkg::SCORE_W-1:0] score_value,
  input  logic                               rsp_valid,
  input  logic                               rsp_ready,
  input  logic [orl_pkg::STATUS_W-1:0]       status,
  input  logic [orl_pkg::POS_W-1:0]          found_position,
  input  logic [orl_pkg::KEY_W-1:0]          out_id,
  input  logic [orl_pkg::KEY_W-1:0]          out_name,
  input  logic [orl_pkg::GENDER_W-1:0]       out_gender,
  input  logic signed [orl_pkg::SCORE_W-1:0] out_score,
  input  logic [orl_pkg::POS_W-1:0]          entry_count,
  output int                                 fail_count,
  output int                                 pending,
  output int                                 results_seen,
  output int                                 list_len
);
  import orl_pkg::*;

  localparam int CAP = CAPACITY_DEF;

  typedef struct {
    status_t          st;
    logic [POS_W-1:0] found;
    rec_t             rec;
    logic [POS_W-1:0] cnt;
  } outcome_t;

  rec_t     rec_mem [CAP];
  int       held;
  outcome_t outcome_q [$];

  // Applies one operation to the shadow list and returns the result it should produce.
  function automatic outcome_t apply_list_op(input op_t op, input int pos, input rec_t entry);
    outcome_t o;
    rec_t     t;
    int       j;
    o.st = ST_OK;
    o.found = '0;
    o.rec = '0;
    case (op)
      OP_INSERT: begin
        if (held >= CAP) o.st = ST_OVERFLOW;
        else if (pos < 1 || pos > held + 1) o.st = ST_BADPOS;
        else begin
          for (j = held; j > pos - 1; j--) rec_mem[j] = rec_mem[j-1];
          rec_mem[pos-1] = entry;
          held++;
        end
      end
      OP_DELETE: begin
        if (held == 0) o.st = ST_UNDERFLOW;
        else if (pos < 1 || pos > held) o.st = ST_BADPOS;
        else begin
          o.rec = rec_mem[pos-1];
          for (j = pos; j < held; j++) rec_mem[j-1] = rec_mem[j];
          held--;
        end
      end
      OP_GET: begin
        if (pos < 1 || pos > held) o.st = ST_BADPOS;
        else o.rec = rec_mem[pos-1];
      end
      OP_MODIFY: begin
        if (pos < 1 || pos > held) o.st = ST_BADPOS;
        else rec_mem[pos-1] = entry;
      end
      OP_LOC_ID, OP_LOC_NAME: begin
        // first match from position 1 upward wins
        for (j = 0; j < held; j++) begin
          if (o.found == 0 && ((op == OP_LOC_ID) ? rec_mem[j].id == entry.id
                                                : rec_mem[j].name == entry.name))
            o.found = POS_W'(j + 1);
        end
      end
      OP_INVERT: begin
        for (j = 0; j < held / 2; j++) begin
          t = rec_mem[j];
          rec_mem[j] = rec_mem[held-1-j];
          rec_mem[held-1-j] = t;
        end
      end
      default: held = 0;
    endcase
    o.cnt = POS_W'(held);
    return o;
  endfunction

  task automatic check_field(input string fname, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, fname, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    outcome_t exp_o;
    rec_t     entry;
    if (rst) begin
      held = 0;
      outcome_q.delete();
      fail_count = 0;
      results_seen = 0;
    end else begin
      // compare before predicting: a result never belongs to the item taken at the same edge
      if (rsp_valid && rsp_ready) begin
        results_seen++;
        if (outcome_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got status %0d count %0d",
                   $time, status, entry_count);
          fail_count++;
        end else begin
          exp_o = outcome_q.pop_front();
          check_field("status", 64'(exp_o.st), 64'(status));
          check_field("found_position", 64'(exp_o.found), 64'(found_position));
          check_field("out_id", exp_o.rec.id, out_id);
          check_field("out_name", exp_o.rec.name, out_name);
          check_field("out_gender", 64'(exp_o.rec.gender), 64'(out_gender));
          check_field("out_score", 64'(unsigned'(exp_o.rec.score)), 64'(unsigned'(out_score)));
          check_field("entry_count", 64'(exp_o.cnt), 64'(entry_count));
        end
      end
      if (req_valid && req_ready) begin
        entry.id = student_id;
        entry.name = student_name;
        entry.gender = gender_code;
        entry.score = score_value;
        outcome_q.push_back(apply_list_op(op_t'(operation), int'(position), entry));
      end
    end
    pending = outcome_q.size();
    list_len = held;
  end

endmodule

FILE: test/tb.sv
// Testbench top for the ordered record list: clock, reset, stimulus and verdict.
module tb;
  import orl_pkg::*;

  localparam int CAP          = CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 800;
  localparam int CYCLE_LIMIT  = 400000;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        req_valid = 1'b0;
  logic                        req_ready;
  logic [OP_W-1:0]             operation = '0;
  logic [POS_W-1:0]            position = '0;
  logic [KEY_W-1:0]            student_id = '0;
  logic [KEY_W-1:0]            student_name = '0;
  logic [GENDER_W-1:0]         gender_code = '0;
  logic signed [SCORE_W-1:0]   score_value = '0;
  logic                        rsp_valid;
  logic                        rsp_ready = 1'b0;
  logic [STATUS_W-1:0]         status;
  logic [POS_W-1:0]            found_position;
  logic [KEY_W-1:0]            out_id;
  logic [KEY_W-1:0]            out_name;
  logic [GENDER_W-1:0]         out_gender;
  logic signed [SCORE_W-1:0]   out_score;
  logic [POS_W-1:0]            entry_count;

  int fails, outstanding, checked, list_len;
  int send_idle = 25;
  int recv_idle = 82;
  int items_sent = 0;
  int peak_len = 0;
  int cycles = 0;
  bit grow = 1'b1;
  logic [KEY_W-1:0] id_pool [8];
  logic [KEY_W-1:0] name_pool [8];

  ordered_record_list #(.CAPACITY(CAP)) u_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready),
    .operation(operation), .position(position),
    .student_id(student_id), .student_name(student_name),
    .gender_code(gender_code), .score_value(score_value),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
    .status(status), .found_position(found_position),
    .out_id(out_id), .out_name(out_name),
    .out_gender(out_gender), .out_score(out_score),
    .entry_count(entry_count)
  );

  orl_checker u_check (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready),
    .operation(operation), .position(position),
    .student_id(student_id), .student_name(student_name),
    .gender_code(gender_code), .score_value(score_value),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
    .status(status), .found_position(found_position),
    .out_id(out_id), .out_name(out_name),
    .out_gender(out_gender), .out_score(out_score),
    .entry_count(entry_count),
    .fail_count(fails), .pending(outstanding),
    .results_seen(checked), .list_len(list_len)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(negedge clk) begin
    rsp_ready = ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, outstanding);
      $display("tb NOT OK");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_item(input op_t op, input int pos, input logic [KEY_W-1:0] id,
                           input logic [KEY_W-1:0] name, input logic [GENDER_W-1:0] g,
                           input logic signed [SCORE_W-1:0] sc);
    while ($urandom_range(99) < send_idle) begin
      req_valid = 1'b0;
      @(negedge clk);
    end
    req_valid = 1'b1;
    operation = op;
    position = pos[POS_W-1:0];
    student_id = id;
    student_name = name;
    gender_code = g;
    score_value = sc;
    do @(posedge clk); while (!req_ready);
    items_sent++;
    @(negedge clk);
    if (list_len > peak_len) peak_len = list_len;
  endtask

  // Hold off the sender until every outstanding result is back.
  task automatic drain_results();
    req_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    @(negedge clk);
  endtask

  function automatic logic [KEY_W-1:0] pick_key(input bit is_name);
    if ($urandom_range(3) != 0) return is_name ? name_pool[$urandom_range(7)]
                                               : id_pool[$urandom_range(7)];
    return {$urandom, $urandom};
  endfunction

  // Mostly a legal position, sometimes anything the field allows.
  function automatic int pick_pos(input int lo, input int hi);
    if ($urandom_range(99) < 85 && hi >= lo) return $urandom_range(hi, lo);
    return $urandom_range(31);
  endfunction

  task automatic random_item();
    int   r;
    int   ins_w;
    int   del_w;
    int   pos;
    op_t  op;
    if (list_len >= CAP) grow = 1'b0;
    else if (list_len == 0) grow = 1'b1;
    else if ($urandom_range(99) < 2) grow = !grow;
    ins_w = grow ? 45 : 15;
    del_w = grow ? 10 : 40;
    r = $urandom_range(99);
    if (r < ins_w) op = OP_INSERT;
    else if (r < ins_w + del_w) op = OP_DELETE;
    else begin
      r = r - ins_w - del_w;
      if (r < 12) op = OP_GET;
      else if (r < 22) op = OP_MODIFY;
      else if (r < 31) op = OP_LOC_ID;
      else if (r < 40) op = OP_LOC_NAME;
      else if (r < 44) op = OP_INVERT;
      else op = OP_CLEAR;
    end
    case (op)
      OP_INSERT: pos = pick_pos(1, list_len + 1);
      OP_DELETE, OP_GET, OP_MODIFY: pos = pick_pos(1, list_len);
      default: pos = $urandom_range(31);
    endcase
    send_item(op, pos, pick_key(1'b0), pick_key(1'b1), GENDER_W'($urandom_range(255)),
              SCORE_W'($urandom_range(65535)));
  endtask

  initial begin
    for (int k = 0; k < 8; k++) begin
      id_pool[k] = {$urandom, $urandom};
      name_pool[k] = {$urandom, $urandom};
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // error cases, then invert and locate, on an empty list
    send_item(OP_DELETE, 1, '0, '0, '0, '0);
    send_item(OP_GET, 1, '0, '0, '0, '0);
    send_item(OP_INSERT, 0, '1, '1, '1, '1);
    send_item(OP_INSERT, 2, '1, '1, '1, '1);
    send_item(OP_INVERT, 0, '0, '0, '0, '0);
    send_item(OP_LOC_ID, 0, '0, '0, '0, '0);
    // fill to capacity, alternating head and tail, field extremes first
    for (int k = 0; k < CAP; k++) begin
      if (k == 0) send_item(OP_INSERT, 1, '1, '0, 8'hff, 16'sh8000);
      else if (k == 1) send_item(OP_INSERT, list_len + 1, '0, '1, 8'h00, 16'sh7fff);
      else send_item(OP_INSERT, (k % 2) ? list_len + 1 : 1, id_pool[k % 8],
                     name_pool[k % 8], GENDER_W'($urandom_range(255)),
                     SCORE_W'($urandom_range(65535)));
    end
    send_item(OP_INSERT, 1, '1, '1, '1, '1);
    send_item(OP_INVERT, 0, '0, '0, '0, '0);
    send_item(OP_LOC_ID, 0, id_pool[2], '0, '0, '0);
    send_item(OP_LOC_NAME, 0, '0, {$urandom, $urandom}, '0, '0);
    send_item(OP_GET, CAP, '0, '0, '0, '0);
    send_item(OP_MODIFY, CAP + 1, '0, '0, '0, '0);
    send_item(OP_DELETE, 0, '0, '0, '0, '0);
    send_item(OP_DELETE, CAP, '0, '0, '0, '0);
    send_item(OP_CLEAR, 0, '0, '0, '0, '0);
    drain_results();

    for (int p = 0; p < 3; p++) begin
      send_idle = (p == 0) ? 25 : (p == 1) ? 82 : 0;
      recv_idle = (p == 0) ? 82 : (p == 1) ? 25 : 0;
      for (int k = 0; k < RANDOM_ITEMS / 3; k++) begin
        random_item();
        if ($urandom_range(99) == 0) drain_results();
      end
      drain_results();
    end

    repeat (2 * CAP + 4) @(negedge clk);
    $display("covered %0d items: directed error and boundary cases, then random traffic",
             items_sent);
    $display("under three stall mixes; %0d results checked, list peaked at %0d records",
             checked, peak_len);
    if (fails == 0 && outstanding == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/orl_pkg.sv
design/orl_cell.sv
design/ordered_record_list.sv
test/orl_checker.sv
test/tb.sv
